@@ src/spm_pkg.sv @@
// shared types, register map, codes and helpers for the spi master port
package spm_pkg;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned EDGE_W    = 5;
  localparam int unsigned PRESC_W   = 7;
  localparam int unsigned ADDR_W    = 5;

  // edges in one byte exchange, minus one
  localparam logic [EDGE_W-1:0] LAST_EDGE = EDGE_W'(2 * BYTE_BITS - 1);

  // spi_mode bits
  localparam int unsigned MODE_CPOL = 1;
  localparam int unsigned MODE_CPHA = 0;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_MODE   = 3'd1;
  localparam logic [2:0] REG_LSB    = 3'd2;
  localparam logic [2:0] REG_RATE   = 3'd3;
  localparam logic [2:0] REG_DOUBLE = 3'd4;

  // item kinds
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  typedef struct packed {
    logic       port_enable;
    logic [1:0] spi_mode;
    logic       lsb_first;
    logic [1:0] clock_rate_select;
    logic       double_speed;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [BYTE_BITS-1:0] write_data;
    logic                 miso_level;
  } item_t;

  typedef struct packed {
    logic                 busy_res;
    logic                 write_collision;
    logic                 transfer_done;
    logic [BYTE_BITS-1:0] read_data;
    logic                 mosi_level;
    logic                 sck_level;
  } result_t;

  // sck half period in clock ticks
  function automatic logic [PRESC_W-1:0] half_period(logic [1:0] sel, logic dbl);
    logic [PRESC_W-1:0] h;
    case (sel)
      2'd0:    h = PRESC_W'(2);
      2'd1:    h = PRESC_W'(8);
      2'd2:    h = PRESC_W'(32);
      default: h = PRESC_W'(64);
    endcase
    return dbl ? (h >> 1) : h;
  endfunction

  function automatic logic [BYTE_BITS-1:0] shift_in(logic [BYTE_BITS-1:0] b,
                                                    logic bit_in, logic lsb);
    if (lsb) begin
      return {bit_in, b[BYTE_BITS-1:1]};
    end
    return {b[BYTE_BITS-2:0], bit_in};
  endfunction

endpackage

@@ src/spm_regs.sv @@
// apb configuration registers of the spi master port
module spm_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output spm_pkg::cfg_t              cfg_o,
  output logic                       abort_o
);

  spm_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic [2:0]    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[spm_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        spm_pkg::REG_ENABLE: cfg_d.port_enable       = pwdata[0];
        spm_pkg::REG_MODE:   cfg_d.spi_mode          = pwdata[1:0];
        spm_pkg::REG_LSB:    cfg_d.lsb_first         = pwdata[0];
        spm_pkg::REG_RATE:   cfg_d.clock_rate_select = pwdata[1:0];
        spm_pkg::REG_DOUBLE: cfg_d.double_speed      = pwdata[0];
        default: ;
      endcase
    end
  end

  // disabling the port kills any exchange in flight
  assign abort_o = wr_en && (reg_idx == spm_pkg::REG_ENABLE) && !pwdata[0];

  always_comb begin
    case (reg_idx)
      spm_pkg::REG_ENABLE: prdata = {31'd0, cfg_q.port_enable};
      spm_pkg::REG_MODE:   prdata = {30'd0, cfg_q.spi_mode};
      spm_pkg::REG_LSB:    prdata = {31'd0, cfg_q.lsb_first};
      spm_pkg::REG_RATE:   prdata = {30'd0, cfg_q.clock_rate_select};
      spm_pkg::REG_DOUBLE: prdata = {31'd0, cfg_q.double_speed};
      default:             prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{port_enable: 1'b0, spi_mode: 2'd0, lsb_first: 1'b0,
                 clock_rate_select: 2'd1, double_speed: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/spm_core.sv @@
// spi engine state and the single-pass update for one transaction
module spm_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  spm_pkg::item_t   item_i,
  input  spm_pkg::cfg_t    cfg_i,
  input  logic             abort_i,
  output spm_pkg::result_t res_o
);

  logic [spm_pkg::PRESC_W-1:0]   pc_q, pc_d;
  logic [spm_pkg::EDGE_W-1:0]    ec_q, ec_d;
  logic [spm_pkg::BYTE_BITS-1:0] sb_q, sb_d;
  logic [spm_pkg::BYTE_BITS-1:0] rb_q, rb_d;
  logic cl_q, cl_d;
  logic act_q, act_d;
  logic done_q, done_d;
  logic coll_q, coll_d;
  logic arm_q, arm_d;
  logic smp_q, smp_d;

  logic [spm_pkg::PRESC_W-1:0] half;
  logic [spm_pkg::PRESC_W:0]   pc_inc;
  logic cpol, cpha, lsb, leading, last;

  assign cpol    = cfg_i.spi_mode[spm_pkg::MODE_CPOL];
  assign cpha    = cfg_i.spi_mode[spm_pkg::MODE_CPHA];
  assign lsb     = cfg_i.lsb_first;
  assign half    = spm_pkg::half_period(cfg_i.clock_rate_select, cfg_i.double_speed);
  assign pc_inc  = {1'b0, pc_q} + 1'b1;
  assign leading = !ec_q[0];
  assign last    = (ec_q >= spm_pkg::LAST_EDGE);

  always_comb begin
    pc_d   = pc_q;
    ec_d   = ec_q;
    sb_d   = sb_q;
    rb_d   = rb_q;
    cl_d   = cl_q;
    act_d  = act_q;
    done_d = done_q;
    coll_d = coll_q;
    arm_d  = arm_q;
    smp_d  = smp_q;
    case (item_i.kind)
      spm_pkg::KIND_TICK: begin
        if (act_q && cfg_i.port_enable) begin
          if (pc_inc >= {1'b0, half}) begin
            pc_d = '0;
            cl_d = ~cl_q;
            if (!cpha) begin
              if (leading) begin
                smp_d = item_i.miso_level;
              end else begin
                sb_d = spm_pkg::shift_in(sb_q, smp_q, lsb);
              end
            end else begin
              if (leading) begin
                if (ec_q != '0) begin
                  sb_d = spm_pkg::shift_in(sb_q, smp_q, lsb);
                end
              end else begin
                smp_d = item_i.miso_level;
                // final trailing edge shifts the fresh sample straight in
                if (last) begin
                  sb_d = spm_pkg::shift_in(sb_q, item_i.miso_level, lsb);
                end
              end
            end
            if (last) begin
              rb_d   = sb_d;
              done_d = 1'b1;
              act_d  = 1'b0;
              ec_d   = '0;
            end else begin
              ec_d = ec_q + 1'b1;
            end
          end else begin
            pc_d = pc_inc[spm_pkg::PRESC_W-1:0];
          end
        end
      end
      spm_pkg::KIND_WRITE: begin
        if (arm_q) begin
          done_d = 1'b0;
          coll_d = 1'b0;
        end
        arm_d = 1'b0;
        if (cfg_i.port_enable) begin
          if (act_q) begin
            coll_d = 1'b1;
          end else begin
            sb_d  = item_i.write_data;
            act_d = 1'b1;
            pc_d  = '0;
            ec_d  = '0;
            cl_d  = cpol;
          end
        end
      end
      spm_pkg::KIND_READ: begin
        if (arm_q) begin
          done_d = 1'b0;
          coll_d = 1'b0;
        end
        arm_d = 1'b0;
      end
      default: begin
        arm_d = done_q;
      end
    endcase
  end

  always_comb begin
    res_o.sck_level       = act_d ? cl_d : cpol;
    res_o.mosi_level      = lsb ? sb_d[0] : sb_d[spm_pkg::BYTE_BITS-1];
    res_o.read_data       = rb_d;
    res_o.transfer_done   = done_d;
    res_o.write_collision = coll_d;
    res_o.busy_res        = act_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      ec_q   <= '0;
      sb_q   <= '0;
      rb_q   <= '0;
      cl_q   <= 1'b0;
      act_q  <= 1'b0;
      done_q <= 1'b0;
      coll_q <= 1'b0;
      arm_q  <= 1'b0;
      smp_q  <= 1'b0;
    end else if (abort_i) begin
      act_q <= 1'b0;
      pc_q  <= '0;
      ec_q  <= '0;
      cl_q  <= cpol;
    end else if (step_i) begin
      pc_q   <= pc_d;
      ec_q   <= ec_d;
      sb_q   <= sb_d;
      rb_q   <= rb_d;
      cl_q   <= cl_d;
      act_q  <= act_d;
      done_q <= done_d;
      coll_q <= coll_d;
      arm_q  <= arm_d;
      smp_q  <= smp_d;
    end
  end

  // counters rest at zero whenever no exchange runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !act_q |-> (ec_q == '0) && (pc_q == '0))
    else $error("counters not cleared while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ec_q <= spm_pkg::LAST_EDGE) && (pc_q < spm_pkg::PRESC_W'(64)))
    else $error("edge or prescale count out of range");

  // done only rises when an exchange finishes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(act_q) && !act_q && $past(step_i))
    else $error("done set without a completed exchange");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(act_q) |-> $past(cfg_i.port_enable) && $past(item_i.kind) == spm_pkg::KIND_WRITE)
    else $error("exchange started without an enabled data write");

endmodule

@@ src/spi_master_port.sv @@
// spi master port top level: stream pipeline around the spi engine
//
// Byte-wide spi master. Each slave-side transaction is one item: tuser
// carries the kind (clock tick, data write, data read, status read) and
// tdata the byte to send and the sampled miso level. Every item gives one
// master-side transaction with the sck and mosi levels, the last received
// byte, the done and collision flags and the busy bit.
// Configuration (enable, mode, bit order, rate select, double speed) is
// written over the apb port, register i at byte address 4*i.
// Each accepted item goes from the input register into the result register.
// Throughput: one item per cycle while the receiver takes results; the
// whole state update is one pass of logic between the input register and
// the result register. Reset clears the control and engine state but not
// the input and result data; rate select resets to 1, everything else to 0.
// When the receiver stalls the result register holds and the input
// register fills, after which tready drops until results drain.
module spi_master_port (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [15:0]                s_axis_tdata,  // write_data[7:0], miso_level[8]
  input  logic [1:0]                 s_axis_tuser,  // kind[1:0]
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // sck_level[0], mosi_level[1], read_data[9:2], transfer_done[10],
  // write_collision[11], busy_res[12]
  output logic [15:0]                m_axis_tdata,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  spm_pkg::cfg_t    cfg;
  spm_pkg::item_t   item_q;
  spm_pkg::result_t res, res_q;
  logic in_vld_q, out_vld_q, advance, step, abort;

  spm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .abort_o (abort)
  );

  assign advance       = !out_vld_q || m_axis_tready;
  assign step          = in_vld_q && advance;
  assign s_axis_tready = !in_vld_q || advance;

  spm_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (item_q),
    .cfg_i   (cfg),
    .abort_i (abort),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.kind       <= s_axis_tuser;
      item_q.write_data <= s_axis_tdata[spm_pkg::BYTE_BITS-1:0];
      item_q.miso_level <= s_axis_tdata[spm_pkg::BYTE_BITS];
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'd0, res_q};

endmodule

@@ test/tb_spi_master_port.sv @@
`timescale 1ns / 100ps
// testbench for spi_master_port: stream items checked against a behavioral spi engine model
module tb_spi_master_port;
  import spm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned NUM_PHASES  = 10;
  localparam int unsigned SETTLE_WAIT = 4;
  localparam int unsigned MAX_SHOWN   = 10;
  localparam int unsigned DIR_SPLIT   = 4;
  localparam logic [15:0] MISO_PAT    = 16'b1011_0010_0110_1101;

  typedef struct {
    item_t   it;
    bit      known;
    result_t res;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [15:0]           m_axis_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // engine model state
  cfg_t                  mcfg;
  logic [PRESC_W-1:0]    m_presc;
  logic [EDGE_W-1:0]     m_edges;
  logic [BYTE_BITS-1:0]  m_shift;
  logic [BYTE_BITS-1:0]  m_rx;
  logic                  m_sck, m_busy, m_done, m_coll, m_armed, m_latch;

  result_t               spi_reply_q[$];
  dir_row_t              dir_tab[$];
  int unsigned           src_idle_pct = 0;
  int unsigned           snk_stall_pct = 0;
  int unsigned           phase_items;
  int unsigned           err_cnt = 0;
  int unsigned           reply_cnt = 0;
  int unsigned           cycle_cnt;

  spi_master_port u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void model_reset();
    mcfg = '0;
    mcfg.clock_rate_select = 2'd1;
    m_presc = '0;
    m_edges = '0;
    m_shift = '0;
    m_rx = '0;
    m_sck = 1'b0;
    m_busy = 1'b0;
    m_done = 1'b0;
    m_coll = 1'b0;
    m_armed = 1'b0;
    m_latch = 1'b0;
  endfunction

  function automatic int unsigned sck_half();
    int unsigned h;
    case (mcfg.clock_rate_select)
      2'd0:    h = 2;
      2'd1:    h = 8;
      2'd2:    h = 32;
      default: h = 64;
    endcase
    if (mcfg.double_speed) begin
      h = h / 2;
    end
    return h;
  endfunction

  function automatic logic [BYTE_BITS-1:0] shifted(logic b);
    if (mcfg.lsb_first) begin
      return {b, m_shift[BYTE_BITS-1:1]};
    end
    return {m_shift[BYTE_BITS-2:0], b};
  endfunction

  // one sck edge: sample or shift depending on phase, latch the byte on the last edge
  function automatic void sck_toggle(logic miso);
    logic lead, cpha, at_end;
    lead   = ~m_edges[0];
    cpha   = mcfg.spi_mode[MODE_CPHA];
    at_end = (int'(m_edges) + 1 >= 2 * BYTE_BITS);
    m_sck  = ~m_sck;
    if (!cpha) begin
      if (lead) begin
        m_latch = miso;
      end else begin
        m_shift = shifted(m_latch);
      end
    end else if (lead) begin
      if (m_edges != '0) begin
        m_shift = shifted(m_latch);
      end
    end else begin
      m_latch = miso;
      if (at_end) begin
        m_shift = shifted(m_latch);
      end
    end
    if (at_end) begin
      m_rx    = m_shift;
      m_done  = 1'b1;
      m_busy  = 1'b0;
      m_edges = '0;
      m_presc = '0;
    end else begin
      m_edges = m_edges + 1'b1;
    end
  endfunction

  function automatic void data_touch();
    if (m_armed) begin
      m_done = 1'b0;
      m_coll = 1'b0;
    end
    m_armed = 1'b0;
  endfunction

  function automatic void cfg_apply(logic [2:0] idx, logic [31:0] v);
    case (idx)
      REG_ENABLE: begin
        mcfg.port_enable = v[0];
        // disabling aborts the exchange in flight
        if (!v[0]) begin
          m_busy  = 1'b0;
          m_presc = '0;
          m_edges = '0;
          m_sck   = mcfg.spi_mode[MODE_CPOL];
        end
      end
      REG_MODE:   mcfg.spi_mode = v[1:0];
      REG_LSB:    mcfg.lsb_first = v[0];
      REG_RATE:   mcfg.clock_rate_select = v[1:0];
      REG_DOUBLE: mcfg.double_speed = v[0];
      default: ;
    endcase
  endfunction

  function automatic result_t spi_step(item_t it);
    result_t r;
    case (it.kind)
      KIND_TICK: begin
        if (m_busy && mcfg.port_enable) begin
          if (int'(m_presc) + 1 >= int'(sck_half())) begin
            m_presc = '0;
            sck_toggle(it.miso_level);
          end else begin
            m_presc = m_presc + 1'b1;
          end
        end
      end
      KIND_WRITE: begin
        data_touch();
        if (mcfg.port_enable) begin
          if (m_busy) begin
            m_coll = 1'b1;
          end else begin
            m_shift = it.write_data;
            m_busy  = 1'b1;
            m_presc = '0;
            m_edges = '0;
            m_sck   = mcfg.spi_mode[MODE_CPOL];
          end
        end
      end
      KIND_READ:   data_touch();
      KIND_STATUS: m_armed = m_done;
      default: ;
    endcase
    r.sck_level       = m_busy ? m_sck : mcfg.spi_mode[MODE_CPOL];
    r.mosi_level      = mcfg.lsb_first ? m_shift[0] : m_shift[BYTE_BITS-1];
    r.read_data       = m_rx;
    r.transfer_done   = m_done;
    r.write_collision = m_coll;
    r.busy_res        = m_busy;
    return r;
  endfunction

  function automatic void note_diff(string fld, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      if (err_cnt <= MAX_SHOWN) begin
        $display("mismatch in %s at output %0d: expected %0h, got %0h",
                 fld, reply_cnt, want, got);
      end
    end
  endfunction

  function automatic void check_reply(result_t got);
    result_t want;
    if (spi_reply_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= MAX_SHOWN) begin
        $display("output transaction %h with nothing pending", got);
      end
      return;
    end
    want = spi_reply_q.pop_front();
    note_diff("sck_level", want.sck_level, got.sck_level);
    note_diff("mosi_level", want.mosi_level, got.mosi_level);
    note_diff("read_data", want.read_data, got.read_data);
    note_diff("transfer_done", want.transfer_done, got.transfer_done);
    note_diff("write_collision", want.write_collision, got.write_collision);
    note_diff("busy_res", want.busy_res, got.busy_res);
    reply_cnt++;
  endfunction

  function automatic item_t any_item(logic [1:0] kind);
    item_t it;
    it.kind       = kind;
    it.write_data = BYTE_BITS'($urandom);
    it.miso_level = 1'($urandom);
    return it;
  endfunction

  function automatic void add_row(logic [1:0] kind, logic [7:0] data, logic miso, bit known);
    dir_row_t row;
    row.it.kind       = kind;
    row.it.write_data = data;
    row.it.miso_level = miso;
    row.known         = known;
    // rows with a known value are all idle-port rows right after reset
    row.res           = '0;
    dir_tab.push_back(row);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_item(item_t it, bit known = 1'b0, result_t fixed = '0);
    result_t r;
    while ($urandom_range(99, 0) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = it.kind;
    s_axis_tdata  = {7'd0, it.miso_level, it.write_data};
    do @(posedge clk); while (!s_axis_tready);
    r = spi_step(it);
    spi_reply_q.push_back(known ? fixed : r);
    phase_items++;
    @(negedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    logic [31:0] rd;
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    cfg_apply(idx, val);
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    note_diff("register readback", val, rd);
  endtask

  task automatic set_config(logic en, logic [1:0] mode, logic lsb, logic [1:0] rate,
                            logic dbl);
    reg_write(REG_ENABLE, {31'd0, en});
    reg_write(REG_MODE, {30'd0, mode});
    reg_write(REG_LSB, {31'd0, lsb});
    reg_write(REG_RATE, {30'd0, rate});
    reg_write(REG_DOUBLE, {31'd0, dbl});
  endtask

  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (spi_reply_q.size() != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  // one byte exchange with random content, sometimes cut short or replaced by noise
  task automatic run_burst(bit full);
    int unsigned n;
    if (!full && $urandom_range(4, 0) == 0) begin
      repeat ($urandom_range(8, 1)) push_item(any_item(2'($urandom_range(3, 0))));
      return;
    end
    push_item(any_item(KIND_WRITE));
    n = 16 * sck_half() + $urandom_range(3, 0);
    if (!full && $urandom_range(7, 0) == 0) begin
      n = $urandom_range(16 * sck_half(), 0);
    end
    repeat (n) begin
      // stray register access in the middle of the exchange
      if ($urandom_range(19, 0) == 0) begin
        push_item(any_item(2'($urandom_range(KIND_STATUS, KIND_WRITE))));
      end
      push_item(any_item(KIND_TICK));
    end
    if ($urandom_range(3, 0) != 0) begin
      push_item(any_item(KIND_STATUS));
    end
    if ($urandom_range(3, 0) != 0) begin
      push_item(any_item(KIND_READ));
    end
  endtask

  always @(negedge clk) begin
    m_axis_tready = rst_n && ($urandom_range(99, 0) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      check_reply(result_t'(m_axis_tdata[12:0]));
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned budget;
    logic [1:0]  rate;
    logic        dbl;
    logic        en;
    bit          big;

    model_reset();
    // idle port right after reset: status, tick, ignored write, data read
    add_row(KIND_STATUS, 8'h00, 1'b0, 1'b1);
    add_row(KIND_TICK, 8'h00, 1'b1, 1'b1);
    add_row(KIND_WRITE, 8'hFF, 1'b1, 1'b1);
    add_row(KIND_READ, 8'h00, 1'b0, 1'b1);
    // fastest sck: start, collide, full byte, then the clearing sequence
    add_row(KIND_WRITE, 8'hA5, 1'b0, 1'b0);
    add_row(KIND_WRITE, 8'h00, 1'b1, 1'b0);
    for (int i = 0; i < 16; i++) begin
      add_row(KIND_TICK, 8'hFF, MISO_PAT[i], 1'b0);
    end
    add_row(KIND_STATUS, 8'h00, 1'b0, 1'b0);
    add_row(KIND_READ, 8'h00, 1'b0, 1'b0);
    add_row(KIND_STATUS, 8'h00, 1'b0, 1'b0);

    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      if (i == DIR_SPLIT) begin
        settle();
        set_config(1'b1, 2'd0, 1'b0, 2'd0, 1'b1);
      end
      push_item(dir_tab[i].it, dir_tab[i].known, dir_tab[i].res);
    end
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct  = 55;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 55;
        end
        default: begin
          src_idle_pct  = 32;
          snk_stall_pct = 32;
        end
      endcase
      rate   = 2'd0;
      dbl    = 1'($urandom);
      en     = (p != 3);
      big    = 1'b0;
      budget = 20;
      // slowest and a middle divider each get one full exchange
      if (p == 8) begin
        rate = 2'd3;
        dbl  = 1'b0;
        big  = 1'b1;
      end else if (p == 5) begin
        rate = 2'd1;
        dbl  = 1'b0;
        big  = 1'b1;
      end
      if (big) begin
        budget = 1;
      end
      set_config(en, 2'(p % 4), 1'((p / 2) % 2), rate, dbl);
      phase_items = 0;
      while (phase_items < budget) run_burst(big);
      settle();
    end

    if (err_cnt == 0 && spi_reply_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
